// ===== design/urh_pkg.sv =====
// ----------------------------------------------------------------------------
// urh_pkg
// Shared types for the undo/redo history stack: the decoded command that
// crosses the front/back queue, and the back-end sequencer states.
// ----------------------------------------------------------------------------
package urh_pkg;

  // Largest caller buffer honored for undo/redo text
  localparam logic [6:0] OUT_LIMIT_MAX = 7'd64;

  // Raw opcodes of the input item
  localparam logic [2:0] OPC_PUSH  = 3'd0;
  localparam logic [2:0] OPC_UNDO  = 3'd1;
  localparam logic [2:0] OPC_REDO  = 3'd2;
  localparam logic [2:0] OPC_CLEAR = 3'd4;

  // Decoded command kinds
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_UNDO,
    CMD_REDO,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_e;

  // One decoded item
  typedef struct packed {
    cmd_e        kind;
    logic [1:0]  entry_op;
    logic [30:0] entry_pos;
    logic [7:0]  text_char;
    logic [7:0]  prev_char;
    logic        item_last;
    logic [6:0]  limit;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_EXEC,
    S_MWAIT,
    S_META,
    S_TRD,
    S_TOUT,
    S_TERM
  } st_e;

endpackage

// ===== design/urh_front.sv =====
// ----------------------------------------------------------------------------
// urh_front
// Input side: accepts items, decodes the opcode and clamps the buffer limit.
// ----------------------------------------------------------------------------
module urh_front import urh_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  entry_op_i,
  input  logic [30:0] entry_pos_i,
  input  logic [7:0]  text_char_i,
  input  logic [7:0]  prev_char_i,
  input  logic        item_last_i,
  input  logic [6:0]  out_limit_i,
  input  logic        q_ready_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  // Accept whenever the queue has room
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  // Classify the item
  always_comb begin
    case (opcode_i)
      OPC_PUSH:  q_cmd_o.kind = CMD_PUSH;
      OPC_UNDO:  q_cmd_o.kind = CMD_UNDO;
      OPC_REDO:  q_cmd_o.kind = CMD_REDO;
      OPC_CLEAR: q_cmd_o.kind = CMD_CLEAR;
      default:   q_cmd_o.kind = CMD_QUERY;
    endcase
    q_cmd_o.entry_op  = entry_op_i;
    q_cmd_o.entry_pos = entry_pos_i;
    q_cmd_o.text_char = text_char_i;
    q_cmd_o.prev_char = prev_char_i;
    q_cmd_o.item_last = item_last_i;
    q_cmd_o.limit     = (out_limit_i > OUT_LIMIT_MAX) ? OUT_LIMIT_MAX : out_limit_i;
  end

endmodule

// ===== design/urh_queue.sv =====
// ----------------------------------------------------------------------------
// urh_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module urh_queue import urh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/urh_back.sv =====
// ----------------------------------------------------------------------------
// urh_back
// Execution side: history state, entry and text memories, result streaming.
// ----------------------------------------------------------------------------
module urh_back import urh_pkg::*; #(
  parameter int HISTORY_DEPTH = 128,
  parameter int TEXT_BYTES    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [1:0]  out_op_o,
  output logic [30:0] out_pos_o,
  output logic [7:0]  out_char_o,
  output logic        char_written_o,
  output logic        run_last_o,
  output logic        can_undo_o,
  output logic        can_redo_o,
  output logic [7:0]  entry_count_o
);

  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LW = $clog2(TEXT_BYTES);
  localparam int AW = $clog2(HISTORY_DEPTH * TEXT_BYTES);
  localparam int TDEPTH = HISTORY_DEPTH * TEXT_BYTES;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(TEXT_BYTES - 1);
  localparam logic [AW-1:0] TB_C = AW'(TEXT_BYTES);

  // Memories
  logic [1:0]    op_mem   [HISTORY_DEPTH];
  logic [30:0]   pos_mem  [HISTORY_DEPTH];
  logic [LW-1:0] nlen_mem [HISTORY_DEPTH];
  logic [LW-1:0] olen_mem [HISTORY_DEPTH];
  logic [7:0]    new_mem  [TDEPTH];
  logic [7:0]    old_mem  [TDEPTH];

  // State
  st_e           state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [SW-1:0] base_q, base_d;
  logic          open_q, open_d;
  logic [1:0]    ended_q, ended_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [LW-1:0] nlen_q, nlen_d;
  logic [LW-1:0] olen_q, olen_d;
  logic          dir_q, dir_d;
  logic [6:0]    lim_q, lim_d;
  logic [LW-1:0] n_q, n_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [1:0]    op_q, op_d;
  logic [30:0]   pos_q, pos_d;

  // Read data
  logic [1:0]    op_rd_q;
  logic [30:0]   pos_rd_q;
  logic [LW-1:0] nlen_rd_q, olen_rd_q;
  logic [7:0]    new_rd_q, old_rd_q;

  // Output register
  logic        out_valid_q;
  logic        status_q, char_written_q, run_last_q, can_undo_q, can_redo_q;
  logic [1:0]  out_op_q;
  logic [30:0] out_pos_q;
  logic [7:0]  out_char_q, entry_count_q;

  // Control
  logic          can_load, load;
  logic          ld_status, ld_wr, ld_last;
  logic [1:0]    ld_op;
  logic [30:0]   ld_pos;
  logic [7:0]    ld_char;
  logic          we_meta, we_len, we_new, we_old;
  logic [CW-1:0] cnt0;
  logic [SW-1:0] base_n, pslot;
  logic [LW-1:0] nlen_cur, olen_cur, nlen_nx, olen_nx, len_sel;
  logic [1:0]    ended_cur, ended_nx;
  logic          take_new, take_old;
  logic [AW-1:0] pbase, wr_new_addr, wr_old_addr, rd_addr;
  logic [8:0]    lim_m1, len9;

  // Ring slot of a logical entry index
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] b,
                                            input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(l);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return SW'(s);
  endfunction

  assign can_load = !out_valid_q || out_ready_i;

  // Open a new entry or continue the current one; form text addresses and the streamed length
  always_comb begin
    cnt0   = cursor_q;
    base_n = base_q;
    if (cursor_q >= DEPTH_C) begin
      base_n = (base_q == LAST_SLOT) ? '0 : base_q + SW'(1);
      cnt0   = cursor_q - CW'(1);
    end
    pslot     = open_q ? slot_q : slot_of(base_n, cnt0);
    nlen_cur  = open_q ? nlen_q : '0;
    olen_cur  = open_q ? olen_q : '0;
    ended_cur = open_q ? ended_q : 2'b00;
    take_new  = !ended_cur[0] && (head_i.text_char != 8'd0) && (nlen_cur < MAX_LEN);
    take_old  = !ended_cur[1] && (head_i.prev_char != 8'd0) && (olen_cur < MAX_LEN);
    nlen_nx   = nlen_cur + LW'(take_new);
    olen_nx   = olen_cur + LW'(take_old);
    ended_nx  = ended_cur | {head_i.prev_char == 8'd0, head_i.text_char == 8'd0};
    pbase       = AW'(pslot) * TB_C;
    wr_new_addr = pbase + AW'(nlen_cur);
    wr_old_addr = pbase + AW'(olen_cur);
    rd_addr     = AW'(slot_q) * TB_C + AW'(idx_q);
    len_sel     = dir_q ? nlen_rd_q : olen_rd_q;
    lim_m1      = 9'(lim_q) - 9'd1;
    len9        = 9'(len_sel);
  end

  // Sequence commands and select the result to load
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    base_d   = base_q;
    open_d   = open_q;
    ended_d  = ended_q;
    slot_d   = slot_q;
    nlen_d   = nlen_q;
    olen_d   = olen_q;
    dir_d    = dir_q;
    lim_d    = lim_q;
    n_d      = n_q;
    idx_d    = idx_q;
    op_d     = op_q;
    pos_d    = pos_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    ld_status = 1'b0;
    ld_wr    = 1'b0;
    ld_last  = 1'b0;
    ld_op    = 2'd0;
    ld_pos   = 31'd0;
    ld_char  = 8'd0;
    we_meta  = 1'b0;
    we_len   = 1'b0;
    we_new   = 1'b0;
    we_old   = 1'b0;
    case (state_q)
      S_EXEC: begin
        if (head_valid_i) begin
          case (head_i.kind)
            CMD_PUSH: begin
              if (can_load) begin
                pop_o   = 1'b1;
                load    = 1'b1;
                ld_last = 1'b1;
                we_meta = !open_q;
                we_len  = 1'b1;
                we_new  = take_new;
                we_old  = take_old;
                if (!open_q) begin
                  base_d   = base_n;
                  count_d  = cnt0 + CW'(1);
                  cursor_d = cnt0 + CW'(1);
                end
                slot_d  = pslot;
                nlen_d  = nlen_nx;
                olen_d  = olen_nx;
                open_d  = !head_i.item_last;
                ended_d = head_i.item_last ? 2'b00 : ended_nx;
              end
            end
            CMD_UNDO: begin
              if (cursor_q == '0) begin
                if (can_load) begin
                  pop_o     = 1'b1;
                  load      = 1'b1;
                  ld_status = 1'b1;
                  ld_last   = 1'b1;
                  open_d    = 1'b0;
                  ended_d   = 2'b00;
                end
              end else begin
                pop_o    = 1'b1;
                open_d   = 1'b0;
                ended_d  = 2'b00;
                cursor_d = cursor_q - CW'(1);
                slot_d   = slot_of(base_q, cursor_q - CW'(1));
                dir_d    = 1'b0;
                lim_d    = head_i.limit;
                state_d  = S_MWAIT;
              end
            end
            CMD_REDO: begin
              if (cursor_q >= count_q) begin
                if (can_load) begin
                  pop_o     = 1'b1;
                  load      = 1'b1;
                  ld_status = 1'b1;
                  ld_last   = 1'b1;
                  open_d    = 1'b0;
                  ended_d   = 2'b00;
                end
              end else begin
                pop_o    = 1'b1;
                open_d   = 1'b0;
                ended_d  = 2'b00;
                cursor_d = cursor_q + CW'(1);
                slot_d   = slot_of(base_q, cursor_q);
                dir_d    = 1'b1;
                lim_d    = head_i.limit;
                state_d  = S_MWAIT;
              end
            end
            CMD_CLEAR: begin
              if (can_load) begin
                pop_o    = 1'b1;
                load     = 1'b1;
                ld_last  = 1'b1;
                count_d  = '0;
                cursor_d = '0;
                base_d   = '0;
                open_d   = 1'b0;
                ended_d  = 2'b00;
              end
            end
            default: begin
              if (can_load) begin
                pop_o   = 1'b1;
                load    = 1'b1;
                ld_last = 1'b1;
                open_d  = 1'b0;
                ended_d = 2'b00;
              end
            end
          endcase
        end
      end
      S_MWAIT: begin
        state_d = S_META;
      end
      S_META: begin
        op_d  = op_rd_q;
        pos_d = pos_rd_q;
        if (lim_q == 7'd0) begin
          if (can_load) begin
            load    = 1'b1;
            ld_op   = op_rd_q;
            ld_pos  = pos_rd_q;
            ld_last = 1'b1;
            state_d = S_EXEC;
          end
        end else begin
          n_d     = (len9 < lim_m1) ? len_sel : LW'(lim_m1);
          idx_d   = '0;
          state_d = (len9 == 9'd0 || lim_m1 == 9'd0) ? S_TERM : S_TRD;
        end
      end
      S_TRD: begin
        state_d = S_TOUT;
      end
      S_TOUT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_op   = op_q;
          ld_pos  = pos_q;
          ld_char = dir_q ? new_rd_q : old_rd_q;
          ld_wr   = 1'b1;
          idx_d   = idx_q + LW'(1);
          state_d = (idx_q + LW'(1) == n_q) ? S_TERM : S_TRD;
        end
      end
      S_TERM: begin
        if (can_load) begin
          load    = 1'b1;
          ld_op   = op_q;
          ld_pos  = pos_q;
          ld_wr   = 1'b1;
          ld_last = 1'b1;
          state_d = S_EXEC;
        end
      end
      default: begin
        state_d = S_EXEC;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      count_q     <= '0;
      cursor_q    <= '0;
      base_q      <= '0;
      open_q      <= 1'b0;
      ended_q     <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      base_q      <= base_d;
      open_q      <= open_d;
      ended_q     <= ended_d;
      out_valid_q <= load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  // Working registers and the result payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    nlen_q <= nlen_d;
    olen_q <= olen_d;
    dir_q  <= dir_d;
    lim_q  <= lim_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    op_q   <= op_d;
    pos_q  <= pos_d;
    if (load) begin
      status_q       <= ld_status;
      out_op_q       <= ld_op;
      out_pos_q      <= ld_pos;
      out_char_q     <= ld_char;
      char_written_q <= ld_wr;
      run_last_q     <= ld_last;
      can_undo_q     <= (cursor_d != '0);
      can_redo_q     <= (cursor_d < count_d);
      entry_count_q  <= (32'(count_d) > 32'd255) ? 8'hFF : 8'(count_d);
    end
  end

  // Entry memories
  always_ff @(posedge clk_i) begin
    if (we_meta) begin
      op_mem[pslot]  <= head_i.entry_op;
      pos_mem[pslot] <= head_i.entry_pos;
    end
    if (we_len) begin
      nlen_mem[pslot] <= nlen_nx;
      olen_mem[pslot] <= olen_nx;
    end
    op_rd_q   <= op_mem[slot_q];
    pos_rd_q  <= pos_mem[slot_q];
    nlen_rd_q <= nlen_mem[slot_q];
    olen_rd_q <= olen_mem[slot_q];
  end

  // Text memories
  always_ff @(posedge clk_i) begin
    if (we_new) begin
      new_mem[wr_new_addr] <= head_i.text_char;
    end
    if (we_old) begin
      old_mem[wr_old_addr] <= head_i.prev_char;
    end
    new_rd_q <= new_mem[rd_addr];
    old_rd_q <= old_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_op_o       = out_op_q;
  assign out_pos_o      = out_pos_q;
  assign out_char_o     = out_char_q;
  assign char_written_o = char_written_q;
  assign run_last_o     = run_last_q;
  assign can_undo_o     = can_undo_q;
  assign can_redo_o     = can_redo_q;
  assign entry_count_o  = entry_count_q;

`ifndef SYNTHESIS
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q) else $error("cursor above entry count");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C) else $error("entry count above depth");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TOUT |-> idx_q < n_q) else $error("text index past length");
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && ld_status |-> !ld_wr && ld_last) else $error("bad refused result");
`endif

endmodule

// ===== design/undo_redo_history_stack.sv =====
// ----------------------------------------------------------------------------
// undo_redo_history_stack
// Bounded undo/redo history with ring eviction and streamed text results.
//
//   channel | direction | handshake              | content
//   input   | in        | in_valid_i/in_ready_o   | opcode, entry, text bytes
//   output  | out       | out_valid_o/out_ready_i | status, text byte, flags
//
// Push, query and clear items are each handled in S_EXEC alone.
// Undo/redo does entry lookup (S_EXEC, S_MWAIT, S_META), then per text byte
// a registered text memory read and load (S_TRD, S_TOUT), then a terminator.
// A two-entry queue decouples input acceptance from execution; the output
// register stalls the back end only while a result waits to be taken.
// Reset clears cursor, count and ring base; memories need no clearing.
// ----------------------------------------------------------------------------
module undo_redo_history_stack import urh_pkg::*; #(
  parameter int HISTORY_DEPTH = 128,
  parameter int TEXT_BYTES    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  entry_op_i,
  input  logic [30:0] entry_pos_i,
  input  logic [7:0]  text_char_i,
  input  logic [7:0]  prev_char_i,
  input  logic        item_last_i,
  input  logic [6:0]  out_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [1:0]  out_op_o,
  output logic [30:0] out_pos_o,
  output logic [7:0]  out_char_o,
  output logic        char_written_o,
  output logic        run_last_o,
  output logic        can_undo_o,
  output logic        can_redo_o,
  output logic [7:0]  entry_count_o
);

  logic q_ready, q_push, q_valid, q_pop;
  cmd_t q_cmd_in, q_head;

  urh_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .entry_op_i  (entry_op_i),
    .entry_pos_i (entry_pos_i),
    .text_char_i (text_char_i),
    .prev_char_i (prev_char_i),
    .item_last_i (item_last_i),
    .out_limit_i (out_limit_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  urh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_head),
    .pop_i   (q_pop)
  );

  urh_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TEXT_BYTES    (TEXT_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_op_o       (out_op_o),
    .out_pos_o      (out_pos_o),
    .out_char_o     (out_char_o),
    .char_written_o (char_written_o),
    .run_last_o     (run_last_o),
    .can_undo_o     (can_undo_o),
    .can_redo_o     (can_redo_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

// ===== test/undo_redo_history_stack_checker.sv =====
// ----------------------------------------------------------------------------
// undo_redo_history_stack_checker
// Watches both channels of the undo/redo history stack, keeps its own copy of
// the history (ring store, cursor, text strings) and compares every result
// item, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module undo_redo_history_stack_checker import urh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  entry_op_i,
  input  logic [30:0] entry_pos_i,
  input  logic [7:0]  text_char_i,
  input  logic [7:0]  prev_char_i,
  input  logic        item_last_i,
  input  logic [6:0]  out_limit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        status_i,
  input  logic [1:0]  out_op_i,
  input  logic [30:0] out_pos_i,
  input  logic [7:0]  out_char_i,
  input  logic        char_written_i,
  input  logic        run_last_i,
  input  logic        can_undo_i,
  input  logic        can_redo_i,
  input  logic [7:0]  entry_count_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 128;
  localparam int TEXT_LEN   = 64;

  typedef struct packed {
    logic        status;
    logic [1:0]  op;
    logic [30:0] pos;
    logic [7:0]  chr;
    logic        written;
    logic        run_last;
    logic        can_undo;
    logic        can_redo;
    logic [7:0]  count;
  } hist_result_t;

  // History mirror
  logic [1:0]  op_mem  [HIST_DEPTH];
  logic [30:0] pos_mem [HIST_DEPTH];
  logic [7:0]  new_txt [HIST_DEPTH][TEXT_LEN];
  logic [7:0]  old_txt [HIST_DEPTH][TEXT_LEN];
  int          new_len [HIST_DEPTH];
  int          old_len [HIST_DEPTH];
  int          entry_cnt, cursor, ring_base, run_cnt;
  bit          new_ended, old_ended;

  hist_result_t expected_q[$];
  int           fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_q.size();

  // Queue one expected result with the current flags
  function automatic void add_result(logic st, logic [1:0] op, logic [30:0] pos,
                                     logic [7:0] ch, logic wr);
    hist_result_t r;
    r.status   = st;
    r.op       = op;
    r.pos      = pos;
    r.chr      = ch;
    r.written  = wr;
    r.run_last = 1'b0;
    r.can_undo = cursor > 0;
    r.can_redo = cursor < entry_cnt;
    r.count    = (entry_cnt > 255) ? 8'd255 : 8'(entry_cnt);
    expected_q.push_back(r);
  endfunction

  // Stream stored text of one entry, bounded by the caller buffer
  function automatic void stream_text(bit use_new, int slot, logic [6:0] lim);
    int lm, n;
    lm = (lim > OUT_LIMIT_MAX) ? int'(OUT_LIMIT_MAX) : int'(lim);
    if (lm == 0) begin
      add_result(1'b0, op_mem[slot], pos_mem[slot], 8'd0, 1'b0);
      return;
    end
    n = use_new ? new_len[slot] : old_len[slot];
    if (n > lm - 1) n = lm - 1;
    for (int i = 0; i < n; i++)
      add_result(1'b0, op_mem[slot], pos_mem[slot],
                 use_new ? new_txt[slot][i] : old_txt[slot][i], 1'b1);
    add_result(1'b0, op_mem[slot], pos_mem[slot], 8'd0, 1'b1);
  endfunction

  // Advance the history by one accepted item and queue its results
  function automatic void predict_history(logic [2:0] opc, logic [1:0] eop,
                                          logic [30:0] epos, logic [7:0] tc,
                                          logic [7:0] pc, logic lastf,
                                          logic [6:0] lim);
    int slot;
    if (opc == OPC_PUSH) begin
      if (run_cnt == 0) begin
        entry_cnt = cursor;
        if (entry_cnt >= HIST_DEPTH) begin
          ring_base = (ring_base + 1) % HIST_DEPTH;
          entry_cnt--;
        end
        slot = (ring_base + entry_cnt) % HIST_DEPTH;
        op_mem[slot]  = eop;
        pos_mem[slot] = epos;
        new_len[slot] = 0;
        old_len[slot] = 0;
        new_ended = 1'b0;
        old_ended = 1'b0;
        entry_cnt++;
        cursor = entry_cnt;
      end
      slot = (ring_base + entry_cnt - 1) % HIST_DEPTH;
      if (!new_ended) begin
        if (tc == 8'd0) new_ended = 1'b1;
        else if (new_len[slot] < TEXT_LEN - 1) begin
          new_txt[slot][new_len[slot]] = tc;
          new_len[slot]++;
        end
      end
      if (!old_ended) begin
        if (pc == 8'd0) old_ended = 1'b1;
        else if (old_len[slot] < TEXT_LEN - 1) begin
          old_txt[slot][old_len[slot]] = pc;
          old_len[slot]++;
        end
      end
      if (lastf) begin
        run_cnt   = 0;
        new_ended = 1'b0;
        old_ended = 1'b0;
      end else if (run_cnt < 127) begin
        run_cnt++;
      end
      add_result(1'b0, 2'd0, 31'd0, 8'd0, 1'b0);
    end else begin
      run_cnt   = 0;
      new_ended = 1'b0;
      old_ended = 1'b0;
      if (opc == OPC_UNDO) begin
        if (cursor == 0) add_result(1'b1, 2'd0, 31'd0, 8'd0, 1'b0);
        else begin
          cursor--;
          stream_text(1'b0, (ring_base + cursor) % HIST_DEPTH, lim);
        end
      end else if (opc == OPC_REDO) begin
        if (cursor >= entry_cnt) add_result(1'b1, 2'd0, 31'd0, 8'd0, 1'b0);
        else begin
          slot = (ring_base + cursor) % HIST_DEPTH;
          cursor++;
          stream_text(1'b1, slot, lim);
        end
      end else begin
        if (opc == OPC_CLEAR) begin
          entry_cnt = 0;
          cursor    = 0;
          ring_base = 0;
        end
        add_result(1'b0, 2'd0, 31'd0, 8'd0, 1'b0);
      end
    end
    expected_q[expected_q.size() - 1].run_last = 1'b1;
  endfunction

  // Predict on accepted input items, then compare accepted result items
  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t got, want;
    if (!rst_ni) begin
      entry_cnt = 0;
      cursor    = 0;
      ring_base = 0;
      run_cnt   = 0;
      new_ended = 1'b0;
      old_ended = 1'b0;
      fail_cnt  = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        predict_history(opcode_i, entry_op_i, entry_pos_i, text_char_i,
                        prev_char_i, item_last_i, out_limit_i);
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, out_op_i, out_pos_i, out_char_i, char_written_i,
                run_last_i, can_undo_i, can_redo_i, entry_count_i};
        if (expected_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result item %p", $realtime, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            $display("%0t: result mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
    end
  end

endmodule

// ===== test/undo_redo_history_stack_tb.sv =====
// ----------------------------------------------------------------------------
// undo_redo_history_stack_tb
// Drives push runs, undo/redo, queries, clears and unused opcodes into the
// history stack with random idling on both sides; the checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module undo_redo_history_stack_tb import urh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OPC_QUERY  = 3'd3;
  localparam logic [2:0] OPC_SPARE0 = 3'd5;
  localparam logic [2:0] OPC_SPARE2 = 3'd7;
  localparam int ITEM_TARGET = 430;
  localparam int IDLE_LIMIT  = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [1:0]  entry_op_i = '0;
  logic [30:0] entry_pos_i = '0;
  logic [7:0]  text_char_i = '0;
  logic [7:0]  prev_char_i = '0;
  logic        item_last_i = 1'b0;
  logic [6:0]  out_limit_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o, char_written_o, run_last_o, can_undo_o, can_redo_o;
  logic [1:0]  out_op_o;
  logic [30:0] out_pos_o;
  logic [7:0]  out_char_o, entry_count_o;
  int          fail_cnt, pending;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  undo_redo_history_stack u_top (.*);

  undo_redo_history_stack_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .entry_op_i,
    .entry_pos_i, .text_char_i, .prev_char_i, .item_last_i, .out_limit_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o), .out_op_i(out_op_o),
    .out_pos_i(out_pos_o), .out_char_i(out_char_o), .char_written_i(char_written_o),
    .run_last_i(run_last_o), .can_undo_i(can_undo_o), .can_redo_i(can_redo_o),
    .entry_count_i(entry_count_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Send one item after a random gap, hold it until accepted
  task automatic send_item(logic [2:0] opc, logic [1:0] eop, logic [30:0] epos,
                           logic [7:0] tc, logic [7:0] pc, logic lastf,
                           logic [6:0] lim);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i    <= opc;
    entry_op_i  <= eop;
    entry_pos_i <= epos;
    text_char_i <= tc;
    prev_char_i <= pc;
    item_last_i <= lastf;
    out_limit_i <= lim;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Undo, redo or other non-push item with random unused fields
  task automatic send_cmd(logic [2:0] opc, logic [6:0] lim);
    send_item(opc, 2'($urandom_range(0, 3)), 31'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom), lim);
  endtask

  // Push run: new and previous strings of given lengths, zero-terminated
  // unless the run is cut short; total run length is items
  task automatic push_run(int items, int new_n, int old_n, bit close);
    logic [1:0]  eop;
    logic [30:0] epos;
    eop  = 2'($urandom_range(0, 2));
    epos = 31'($urandom);
    for (int i = 0; i < items; i++)
      send_item(OPC_PUSH, i == 0 ? eop : 2'($urandom_range(0, 2)),
                i == 0 ? epos : 31'($urandom),
                i < new_n ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255) * (i > new_n)),
                i < old_n ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255) * (i > old_n)),
                close && (i == items - 1), 7'($urandom));
  endtask

  // Hold off the sender until every expected result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall per result item
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[undo_redo_history_stack] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sel, n, m;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty history, extremes, limits, spare opcodes, clear
    send_cmd(OPC_QUERY, 7'd0);
    send_cmd(OPC_UNDO, 7'd10);
    send_cmd(OPC_REDO, 7'd10);
    send_item(OPC_PUSH, 2'd2, 31'h7FFF_FFFF, 8'hFF, 8'h00, 1'b0, 7'h7F);
    send_item(OPC_PUSH, 2'd2, 31'd0, 8'h01, 8'hAA, 1'b0, 7'd0);
    send_item(OPC_PUSH, 2'd0, 31'd5, 8'h00, 8'h00, 1'b1, 7'd0);
    send_item(OPC_PUSH, 2'd0, 31'd0, 8'h00, 8'h00, 1'b1, 7'd0);
    send_item(OPC_PUSH, 2'd1, 31'h5555_5555, 8'h80, 8'h7F, 1'b1, 7'd0);
    send_cmd(OPC_UNDO, 7'd0);
    send_cmd(OPC_UNDO, 7'h7F);
    send_cmd(OPC_UNDO, 7'd64);
    send_cmd(OPC_UNDO, 7'd5);
    send_cmd(OPC_REDO, 7'd1);
    send_cmd(OPC_REDO, 7'd2);
    send_cmd(OPC_REDO, 7'd65);
    for (int op = OPC_SPARE0; op <= OPC_SPARE2; op++) send_cmd(3'(op), 7'd3);
    send_item(OPC_PUSH, 2'd1, 31'd9, 8'h41, 8'h42, 1'b0, 7'd0);
    send_cmd(OPC_CLEAR, 7'd0);
    send_cmd(OPC_UNDO, 7'd8);
    send_cmd(OPC_REDO, 7'd8);
    drain();

    // Fill past the depth so the ring base advances
    for (int i = 0; i < 135; i++) push_run(1, 0, 0, 1'b1);
    for (int i = 0; i < 3; i++) send_cmd(OPC_UNDO, 7'd4);
    push_run(2, 1, 1, 1'b1);
    drain();

    // Mixed traffic
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        n = $urandom_range(0, 4);
        m = $urandom_range(0, 4);
        push_run((n > m ? n : m) + 1 + $urandom_range(0, 1), n, m, 1'b1);
      end else if (sel < 44) begin
        n = $urandom_range(60, 70);
        push_run(n + 2, n, $urandom_range(0, 70), 1'b1);
      end else if (sel < 62) begin
        send_cmd(OPC_UNDO, $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 8)));
      end else if (sel < 78) begin
        send_cmd(OPC_REDO, $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 8)));
      end else if (sel < 83) begin
        send_cmd(OPC_QUERY, 7'($urandom));
      end else if (sel < 86) begin
        send_cmd(OPC_CLEAR, 7'($urandom));
      end else if (sel < 90) begin
        send_cmd(3'($urandom_range(OPC_SPARE0, OPC_SPARE2)), 7'($urandom));
      end else if (sel < 91 && items_sent < 250) begin
        push_run(132, 70, 3, 1'b1);
      end else begin
        push_run($urandom_range(1, 4), $urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
        send_cmd($urandom_range(0, 1) ? OPC_UNDO : OPC_QUERY, 7'($urandom));
      end
      if ($urandom_range(0, 99) == 0) drain();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[undo_redo_history_stack] OK");
    end else begin
      $display("[undo_redo_history_stack] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/urh_pkg.sv
design/urh_front.sv
design/urh_queue.sv
design/urh_back.sv
design/undo_redo_history_stack.sv
test/undo_redo_history_stack_checker.sv
test/undo_redo_history_stack_tb.sv
